>>> rtl/coincidence_gated_histogrammer_assert.svh
// assertion macros for the coincidence gated histogrammer checker
// used by cgh_checker.sv only, no other dependencies
`ifndef COINCIDENCE_GATED_HISTOGRAMMER_ASSERT_SVH
`define COINCIDENCE_GATED_HISTOGRAMMER_ASSERT_SVH

// property checked only while reset is released
`define CGH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// property checked at every edge, reset included
`define CGH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

>>> rtl/cgh_pkg.sv
// shared constants, types and codes of the coincidence gated histogrammer
// no dependencies; used by every rtl file but cgh_ram and the assertion header
`default_nettype none

package cgh_pkg;

  // sizes of the stores
  localparam int MAX_HITS  = 16;
  localparam int NUM_BINS  = 2048;

  // field widths
  localparam int ENERGY_W    = 16;
  localparam int ALPHA_W     = 4;
  localparam int BIN_IDX_W   = 11;
  localparam int COUNT_W     = 32;
  localparam int BIN_SHIFT   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // derived widths
  localparam int HIT_IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int HIT_CNT_W = $clog2(MAX_HITS + 1);
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int EBIN_W    = ENERGY_W - BIN_SHIFT;

  // event acceptance constants
  localparam int MIN_HITS = 2;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_LOW     = 2'd0,
    CFG_GATE_HIGH    = 2'd1,
    CFG_SINGLE_ALPHA = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_HIT  = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [ENERGY_W-1:0] gate_low;
    logic [ENERGY_W-1:0] gate_high;
    logic                single_alpha;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/cgh_in_if.sv
// input channel: hits and bin read requests
// depends on cgh_pkg
`default_nettype none

interface cgh_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [cgh_pkg::ENERGY_W-1:0]   energy;
  logic                           event_end;
  logic [cgh_pkg::ALPHA_W-1:0]    alpha_count;
  logic [cgh_pkg::BIN_IDX_W-1:0]  bin_index;

  modport source (output valid, opcode, energy, event_end, alpha_count, bin_index,
                  input ready);
  modport sink   (input valid, opcode, energy, event_end, alpha_count, bin_index,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/cgh_out_if.sv
// result channel: one histogram bin per read request
// depends on cgh_pkg
`default_nettype none

interface cgh_out_if;
  logic                           valid;
  logic                           ready;
  logic [cgh_pkg::COUNT_W-1:0]    bin_count;
  logic [cgh_pkg::BIN_IDX_W-1:0]  bin_echo;

  modport source (output valid, bin_count, bin_echo, input ready);
  modport sink   (input valid, bin_count, bin_echo, output ready);
endinterface

`default_nettype wire

>>> rtl/cgh_cfg_if.sv
// configuration write channel: register index and write data
// depends on cgh_pkg
`default_nettype none

interface cgh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cgh_pkg::CFG_IDX_W-1:0]   index;
  logic [cgh_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/cgh_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
`default_nettype none

module cgh_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire  [WIDTH-1:0]             wdata_i,
  input  wire                          re_i,
  input  wire  [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/cgh_cfg_regs.sv
// configuration registers: gate window and alpha mode
// depends on cgh_pkg and cgh_cfg_if
`default_nettype none

module cgh_cfg_regs (
  input  wire             clk_i,
  input  wire             rst_ni,
  cgh_cfg_if.sink         cfg_i,
  output cgh_pkg::cfg_t   cfg_o
);

  cgh_pkg::cfg_t cfg_q;
  cgh_pkg::cfg_t cfg_d;
  logic          wr_fire;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_fire     = cfg_i.valid;

  // register decode, unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_fire) begin
      case (cgh_pkg::cfg_idx_e'(cfg_i.index))
        cgh_pkg::CFG_GATE_LOW:     cfg_d.gate_low     = cfg_i.data;
        cgh_pkg::CFG_GATE_HIGH:    cfg_d.gate_high    = cfg_i.data;
        cgh_pkg::CFG_SINGLE_ALPHA: cfg_d.single_alpha = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/cgh_ctrl.sv
// sequencer and datapath: hit buffering, gate search, histogram update and readout
// depends on cgh_pkg, cgh_ram, cgh_in_if and cgh_out_if
`default_nettype none

module cgh_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  cgh_pkg::cfg_t   cfg_i,
  cgh_in_if.sink          in_i,
  cgh_out_if.source       res_o
);

  localparam int HIW = cgh_pkg::HIT_IDX_W;
  localparam int HCW = cgh_pkg::HIT_CNT_W;
  localparam int BW  = cgh_pkg::BIN_W;
  localparam int EW  = cgh_pkg::ENERGY_W;
  localparam int CW  = cgh_pkg::COUNT_W;

  cgh_pkg::state_e state_q, state_d;

  // control registers
  logic [BW-1:0]  clr_addr_q, clr_addr_d;
  logic [HCW-1:0] hit_total_q, hit_total_d;
  logic [HCW-1:0] srch_idx_q, srch_idx_d;
  logic           srch_v_q, srch_v_d;
  logic [HIW-1:0] srch_at_q, srch_at_d;
  logic [HIW-1:0] gate_at_q, gate_at_d;
  logic [HCW-1:0] w_idx_q, w_idx_d;
  logic           s1_v_q, s1_v_d;
  logic           s2_v_q, s2_v_d;
  logic           wr_v_q, wr_v_d;
  logic           out_valid_q, out_valid_d;

  // payload registers
  logic [BW-1:0]  s2_addr_q, s2_addr_d;
  logic [BW-1:0]  wr_addr_q, wr_addr_d;
  logic [CW-1:0]  wr_data_q, wr_data_d;
  logic [cgh_pkg::BIN_IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic           rd_oob_q, rd_oob_d;
  logic [CW-1:0]  out_count_q, out_count_d;
  logic [cgh_pkg::BIN_IDX_W-1:0] out_echo_q, out_echo_d;

  // memory ports
  logic           buf_we, buf_re;
  logic [HIW-1:0] buf_waddr, buf_raddr;
  logic [EW-1:0]  buf_rdata;
  logic           hist_we, hist_re;
  logic [BW-1:0]  hist_waddr, hist_raddr;
  logic [CW-1:0]  hist_wdata, hist_rdata;

  // decoded conditions
  logic                    in_fire, hit_fire, rd_fire;
  logic                    buf_full, event_keep, clr_done;
  logic [HCW-1:0]          total_next;
  logic                    srch_hit, srch_last;
  logic                    w_more, w_issue, walk_done;
  logic [cgh_pkg::EBIN_W-1:0] ebin;
  logic                    ebin_ok;
  logic [CW-1:0]           old_count, new_count;
  logic                    out_free;

  cgh_ram #(.DEPTH(cgh_pkg::MAX_HITS), .WIDTH(EW)) u_hit_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (in_i.energy),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  cgh_ram #(.DEPTH(cgh_pkg::NUM_BINS), .WIDTH(CW)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // input handshake
  assign in_i.ready = (state_q == cgh_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign hit_fire   = in_fire && (in_i.opcode == cgh_pkg::OP_HIT);
  assign rd_fire    = in_fire && (in_i.opcode == cgh_pkg::OP_READ);

  // event judgement at the closing hit
  assign buf_full   = (hit_total_q == HCW'(cgh_pkg::MAX_HITS));
  assign total_next = buf_full ? hit_total_q : hit_total_q + HCW'(1);
  assign event_keep = (total_next >= HCW'(cgh_pkg::MIN_HITS)) &&
                      (!cfg_i.single_alpha || (in_i.alpha_count == cgh_pkg::ALPHA_ONE));

  assign clr_done = (clr_addr_q == BW'(cgh_pkg::NUM_BINS - 1));

  // gate search compare on the buffer read data
  assign srch_hit  = (buf_rdata > cfg_i.gate_low) && (buf_rdata < cfg_i.gate_high);
  assign srch_last = (HCW'(srch_at_q) == hit_total_q - HCW'(1));

  // walk issue stage skips the gate hit
  assign w_more    = (w_idx_q < hit_total_q);
  assign w_issue   = w_more && (w_idx_q[HIW-1:0] != gate_at_q);
  assign walk_done = !w_more && !s1_v_q && !s2_v_q;

  // bin of the buffered energy
  assign ebin    = buf_rdata[EW-1:cgh_pkg::BIN_SHIFT];
  assign ebin_ok = (32'(ebin) < 32'(cgh_pkg::NUM_BINS));

  // increment with forwarding of the previous cycle's write
  assign old_count = (wr_v_q && (wr_addr_q == s2_addr_q)) ? wr_data_q : hist_rdata;
  assign new_count = (old_count == cgh_pkg::COUNT_MAX) ? old_count : old_count + CW'(1);

  assign out_free = !out_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cgh_pkg::ST_CLEAR: begin
        if (clr_done) state_d = cgh_pkg::ST_IDLE;
      end
      cgh_pkg::ST_IDLE: begin
        if (rd_fire) begin
          state_d = cgh_pkg::ST_READ;
        end else if (hit_fire && in_i.event_end && event_keep) begin
          state_d = cgh_pkg::ST_SEARCH;
        end
      end
      cgh_pkg::ST_READ: begin
        if (out_free) state_d = cgh_pkg::ST_IDLE;
      end
      cgh_pkg::ST_SEARCH: begin
        if (srch_v_q && srch_hit) begin
          state_d = cgh_pkg::ST_WALK;
        end else if (srch_v_q && srch_last) begin
          state_d = cgh_pkg::ST_IDLE;
        end
      end
      cgh_pkg::ST_WALK: begin
        if (walk_done) state_d = cgh_pkg::ST_IDLE;
      end
      default: state_d = cgh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: memory ports and register next values
  always_comb begin
    clr_addr_d  = clr_addr_q;
    hit_total_d = hit_total_q;
    srch_idx_d  = srch_idx_q;
    srch_v_d    = 1'b0;
    srch_at_d   = srch_at_q;
    gate_at_d   = gate_at_q;
    w_idx_d     = w_idx_q;
    s1_v_d      = 1'b0;
    s2_v_d      = 1'b0;
    s2_addr_d   = s2_addr_q;
    wr_v_d      = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    rd_idx_d    = rd_idx_q;
    rd_oob_d    = rd_oob_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_count_d = out_count_q;
    out_echo_d  = out_echo_q;

    buf_we     = 1'b0;
    buf_waddr  = hit_total_q[HIW-1:0];
    buf_re     = 1'b0;
    buf_raddr  = srch_idx_q[HIW-1:0];
    hist_we    = 1'b0;
    hist_waddr = s2_addr_q;
    hist_wdata = new_count;
    hist_re    = 1'b0;
    hist_raddr = BW'(ebin);

    case (state_q)
      // sweep the histogram to zero after reset
      cgh_pkg::ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_addr_q;
        hist_wdata = '0;
        clr_addr_d = clr_addr_q + BW'(1);
      end
      // take hits into the buffer, start reads
      cgh_pkg::ST_IDLE: begin
        if (hit_fire) begin
          buf_we      = !buf_full;
          hit_total_d = (in_i.event_end && !event_keep) ? '0 : total_next;
          srch_idx_d  = '0;
        end
        if (rd_fire) begin
          hist_re    = 1'b1;
          hist_raddr = BW'(in_i.bin_index);
          rd_idx_d   = in_i.bin_index;
          rd_oob_d   = (32'(in_i.bin_index) >= 32'(cgh_pkg::NUM_BINS));
        end
      end
      // hand the read bin to the output register
      cgh_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = rd_oob_q ? '0 : hist_rdata;
          out_echo_d  = rd_idx_q;
        end
      end
      // walk the buffer for the first hit inside the gate
      cgh_pkg::ST_SEARCH: begin
        if (srch_idx_q < hit_total_q) begin
          buf_re     = 1'b1;
          srch_v_d   = 1'b1;
          srch_at_d  = srch_idx_q[HIW-1:0];
          srch_idx_d = srch_idx_q + HCW'(1);
        end
        if (srch_v_q && srch_hit) begin
          gate_at_d = srch_at_q;
          w_idx_d   = '0;
          srch_v_d  = 1'b0;
        end else if (srch_v_q && srch_last) begin
          hit_total_d = '0;
          srch_v_d    = 1'b0;
        end
      end
      // three-stage walk: buffer read, bin read, bin write
      cgh_pkg::ST_WALK: begin
        buf_re    = w_issue;
        buf_raddr = w_idx_q[HIW-1:0];
        if (w_more) w_idx_d = w_idx_q + HCW'(1);
        s1_v_d    = w_issue;
        hist_re   = s1_v_q && ebin_ok;
        s2_v_d    = s1_v_q && ebin_ok;
        s2_addr_d = BW'(ebin);
        hist_we   = s2_v_q;
        wr_v_d    = s2_v_q;
        wr_addr_d = s2_addr_q;
        wr_data_d = new_count;
        if (walk_done) hit_total_d = '0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cgh_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      hit_total_q <= '0;
      srch_idx_q  <= '0;
      srch_v_q    <= 1'b0;
      srch_at_q   <= '0;
      gate_at_q   <= '0;
      w_idx_q     <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      wr_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      hit_total_q <= hit_total_d;
      srch_idx_q  <= srch_idx_d;
      srch_v_q    <= srch_v_d;
      srch_at_q   <= srch_at_d;
      gate_at_q   <= gate_at_d;
      w_idx_q     <= w_idx_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      wr_v_q      <= wr_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s2_addr_q   <= s2_addr_d;
    wr_addr_q   <= wr_addr_d;
    wr_data_q   <= wr_data_d;
    rd_idx_q    <= rd_idx_d;
    rd_oob_q    <= rd_oob_d;
    out_count_q <= out_count_d;
    out_echo_q  <= out_echo_d;
  end

  // result channel
  assign res_o.valid     = out_valid_q;
  assign res_o.bin_count = out_count_q;
  assign res_o.bin_echo  = out_echo_q;

endmodule

`default_nettype wire

>>> rtl/coincidence_gated_histogrammer.sv
// Coincidence gated histogrammer, top level.
// Channels: in_i takes one beat per hit (opcode 0) or per bin read (opcode 1);
// res_o returns one beat per bin read with the count and the echoed index;
// cfg_i writes gate_low (0), gate_high (1) and require_single_alpha (2).
// A hit beat that does not close a kept event leaves in_i ready. The beat that
// closes a kept event starts a gate search over the buffered hits (one buffer
// read per cycle) and, if a hit lies inside the gate, a histogram walk that
// reads and writes one bin per cycle through a three-stage pipeline, issuing
// one buffer read per cycle. No beat is taken during search or walk.
// After a bin read beat, in_i is not ready until the result, read through the
// histogram ram's read register, enters the output register. That register
// holds the result while res_o is stalled; hits are still taken during such a
// stall, a second read waits until the register is free.
// Reset clears the control and configuration registers and starts a clearing
// pass over every bin of the histogram, during which in_i is not ready;
// configuration writes are taken at any time.
// depends on cgh_pkg, the channel interfaces, cgh_cfg_regs and cgh_ctrl
`default_nettype none

module coincidence_gated_histogrammer (
  input  wire         clk_i,
  input  wire         rst_ni,
  cgh_in_if.sink      in_i,
  cgh_out_if.source   res_o,
  cgh_cfg_if.sink     cfg_i
);

  cgh_pkg::cfg_t cfg;

  // configuration registers
  cgh_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // event sequencer and histogram
  cgh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

>>> rtl/cgh_checker.sv
// port-level checks for the coincidence gated histogrammer, bound to the top level
// depends on cgh_pkg and coincidence_gated_histogrammer_assert.svh
`default_nettype none
`include "coincidence_gated_histogrammer_assert.svh"

module cgh_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_ready_i,
  input wire                                res_valid_i,
  input wire                                res_ready_i,
  input wire [cgh_pkg::COUNT_W-1:0]         res_count_i,
  input wire [cgh_pkg::BIN_IDX_W-1:0]       res_echo_i
);

  logic                                          res_stall;
  logic [cgh_pkg::COUNT_W+cgh_pkg::BIN_IDX_W-1:0] res_beat;

  // result beat waiting on the receiver
  assign res_stall = res_valid_i && !res_ready_i;
  assign res_beat  = {res_count_i, res_echo_i};

  // result beat stays up until taken
  `CGH_ASSERT(a_res_hold, clk_i, rst_ni, res_stall |=> res_valid_i)

  // stalled result keeps its payload
  `CGH_ASSERT(a_res_stable, clk_i, rst_ni, res_stall |=> $stable(res_beat))

  // no result while reset is applied
  `CGH_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !res_valid_i)

  // clearing pass blocks input right after reset
  `CGH_ASSERT(a_clear_blocks, clk_i, rst_ni, !$past(rst_ni) |-> !in_ready_i)

endmodule

bind coincidence_gated_histogrammer cgh_checker u_cgh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_count_i (res_o.bin_count),
  .res_echo_i  (res_o.bin_echo)
);

`default_nettype wire

>>> dv/tb_coincidence_gated_histogrammer.sv
// testbench for the coincidence gated histogrammer: gated events, bin reads, config phases
// needs cgh_pkg, the cgh channel interfaces and the coincidence_gated_histogrammer rtl
`timescale 1ns / 1ps

module tb_coincidence_gated_histogrammer;
  import cgh_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int SETTLE_CYCLES  = 2 * MAX_HITS + 8;

  typedef struct {
    opcode_e                opcode;
    logic [ENERGY_W-1:0]    energy;
    logic                   event_end;
    logic [ALPHA_W-1:0]     alpha_count;
    logic [BIN_IDX_W-1:0]   bin_index;
  } beat_t;

  typedef struct {
    logic [COUNT_W-1:0]     count;
    logic [BIN_IDX_W-1:0]   echo;
  } bin_readout_t;

  typedef enum {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_e;

  // mirror of the gate, the event buffer and the histogram, plus the reads still owed
  class gate_histogram_sb;
    logic [ENERGY_W-1:0]  gate_lo;
    logic [ENERGY_W-1:0]  gate_hi;
    bit                   single_alpha;
    logic [ENERGY_W-1:0]  event_hits[MAX_HITS];
    int                   n_hits;
    logic [COUNT_W-1:0]   hist_bins[NUM_BINS];
    bin_readout_t         pending_reads[$];
    int                   errors;
    int                   reads_ok;
    int                   hits_taken;
    int                   events_closed;
    int                   events_counted;

    function new();
      gate_lo = '0;
      gate_hi = '0;
      single_alpha = 1'b0;
      n_hits = 0;
      foreach (hist_bins[i]) hist_bins[i] = '0;
      errors = 0;
      reads_ok = 0;
      hits_taken = 0;
      events_closed = 0;
      events_counted = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GATE_LOW:     gate_lo = data[ENERGY_W-1:0];
        CFG_GATE_HIGH:    gate_hi = data[ENERGY_W-1:0];
        CFG_SINGLE_ALPHA: single_alpha = data[0];
        default: ;
      endcase
    endfunction

    // judge the buffered event and fill the histogram from the non-gate hits
    function void close_event(logic [ALPHA_W-1:0] alphas);
      int gate_at;
      int k;
      int bin;
      gate_at = -1;
      events_closed++;
      if (n_hits < MIN_HITS) return;
      if (single_alpha && alphas != ALPHA_ONE) return;
      for (k = 0; k < n_hits; k++) begin
        if (gate_at < 0 && event_hits[k] > gate_lo && event_hits[k] < gate_hi) gate_at = k;
      end
      if (gate_at < 0) return;
      events_counted++;
      for (k = 0; k < n_hits; k++) begin
        bin = int'(event_hits[k] >> BIN_SHIFT);
        if (k != gate_at && bin < NUM_BINS && hist_bins[bin] != COUNT_MAX) hist_bins[bin]++;
      end
    endfunction

    function void note_beat(beat_t b);
      bin_readout_t r;
      if (b.opcode == OP_READ) begin
        r.count = (int'(b.bin_index) < NUM_BINS) ? hist_bins[int'(b.bin_index)] : '0;
        r.echo  = b.bin_index;
        pending_reads.push_back(r);
        return;
      end
      hits_taken++;
      if (n_hits < MAX_HITS) begin
        event_hits[n_hits] = b.energy;
        n_hits++;
      end
      if (b.event_end) begin
        close_event(b.alpha_count);
        n_hits = 0;
      end
    endfunction

    function void check_readout(logic [COUNT_W-1:0] count, logic [BIN_IDX_W-1:0] echo);
      bin_readout_t want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result beat, actual bin_count %0d bin_echo %0d",
                 $time, count, echo);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      if (count !== want.count) begin
        $display("%0t: bin_count mismatch on bin %0d, expected %0d, actual %0d",
                 $time, want.echo, want.count, count);
        errors++;
      end
      if (echo !== want.echo) begin
        $display("%0t: bin_echo mismatch, expected %0d, actual %0d", $time, want.echo, echo);
        errors++;
      end
      if (count === want.count && echo === want.echo) reads_ok++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cgh_in_if  in_if ();
  cgh_out_if res_if ();
  cgh_cfg_if cfg_if ();

  coincidence_gated_histogrammer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  gate_histogram_sb hist_sb;
  beat_t            beat_q[$];
  int               idle_run;
  int               n_settings;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: open, coin-flip and stall-run patterns, with the pattern picked anew at random
  initial begin
    rx_mode_e mode;
    int       left;
    int       stall;
    res_if.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        left = int'($urandom_range(20, 80));
      end
      left--;
      case (mode)
        RX_OPEN: res_if.ready <= 1'b1;
        RX_COIN: res_if.ready <= ($urandom_range(0, 1) == 1);
        default: begin
          if (stall > 0) begin
            stall--;
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = int'($urandom_range(1, 8));
          end
        end
      endcase
    end
  end

  // accepted input beats and taken result beats go to the scoreboard; watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    beat_t seen;
    bit    moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen.opcode      = opcode_e'(in_if.opcode);
        seen.energy      = in_if.energy;
        seen.event_end   = in_if.event_end;
        seen.alpha_count = in_if.alpha_count;
        seen.bin_index   = in_if.bin_index;
        hist_sb.note_beat(seen);
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        hist_sb.check_readout(res_if.bin_count, res_if.bin_echo);
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) moved = 1'b1;
    end
    if (moved) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d reads still pending",
               $time, idle_run, hist_sb.pending_reads.size());
      $display("tb_coincidence_gated_histogrammer: FAIL");
      $finish;
    end
  end

  function automatic void push_hit(logic [ENERGY_W-1:0] e, logic last,
                                   logic [ALPHA_W-1:0] alpha);
    beat_t b;
    b.opcode      = OP_HIT;
    b.energy      = e;
    b.event_end   = last;
    b.alpha_count = alpha;
    b.bin_index   = BIN_IDX_W'($urandom_range(0, NUM_BINS - 1));
    beat_q.push_back(b);
  endfunction

  // on a read the hit fields are don't-care, so fill them with noise
  function automatic void push_read(logic [BIN_IDX_W-1:0] idx);
    beat_t b;
    b.opcode      = OP_READ;
    b.energy      = ENERGY_W'($urandom_range(0, 16'hFFFF));
    b.event_end   = ($urandom_range(0, 1) == 1);
    b.alpha_count = ALPHA_W'($urandom_range(0, 15));
    b.bin_index   = idx;
    beat_q.push_back(b);
  endfunction

  // low bins half of the time so reads find real counts, some high and gate-edge energies
  function automatic int pick_energy();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 16 * 32 - 1));
      5:             return int'($urandom_range(16'h8000, 16'hFFFF));
      6:             return ($urandom_range(0, 1) != 0) ? int'(hist_sb.gate_lo)
                                                        : int'(hist_sb.gate_hi);
      default:       return int'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic int pick_bin();
    case ($urandom_range(0, 9))
      0:       return NUM_BINS - 1;
      1, 2, 3: return int'($urandom_range(0, NUM_BINS - 1));
      default: return int'($urandom_range(0, 31));
    endcase
  endfunction

  // well-formed events with random content, reads between and inside events
  function automatic void gen_run(int n);
    int                  added;
    int                  len;
    int                  gpos;
    int                  k;
    int                  e;
    bit                  gate_ok;
    logic [ALPHA_W-1:0]  alpha;
    added = 0;
    gate_ok = int'(hist_sb.gate_hi) > int'(hist_sb.gate_lo) + 1;
    while (added < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_read(BIN_IDX_W'(pick_bin()));
        added++;
      end else begin
        case ($urandom_range(0, 19))
          0:       len = 1;
          1:       len = int'($urandom_range(MAX_HITS - 1, MAX_HITS + 4));
          default: len = int'($urandom_range(2, 6));
        endcase
        gpos = -1;
        if (gate_ok && $urandom_range(0, 9) < 8) gpos = int'($urandom_range(0, len - 1));
        for (k = 0; k < len; k++) begin
          e = pick_energy();
          if (k == gpos)
            e = int'($urandom_range(int'(hist_sb.gate_lo) + 1, int'(hist_sb.gate_hi) - 1));
          alpha = ALPHA_W'($urandom_range(0, 15));
          if (k == len - 1 && hist_sb.single_alpha && $urandom_range(0, 3) != 0)
            alpha = ALPHA_ONE;
          push_hit(e[ENERGY_W-1:0], k == len - 1, alpha);
          added++;
          if (k < len - 1 && $urandom_range(0, 15) == 0) begin
            push_read(BIN_IDX_W'(pick_bin()));
            added++;
          end
        end
      end
    end
  endfunction

  // send the queued beats in bursts with random gaps, some long gap-free bursts
  task automatic drive_beats();
    beat_t b;
    int    burst;
    int    gap;
    burst = 0;
    while (beat_q.size() > 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = ($urandom_range(0, 7) == 0) ? 64 : int'($urandom_range(1, 16));
      end
      b = beat_q.pop_front();
      in_if.valid       <= 1'b1;
      in_if.opcode      <= b.opcode;
      in_if.energy      <= b.energy;
      in_if.event_end   <= b.event_end;
      in_if.alpha_count <= b.alpha_count;
      in_if.bin_index   <= b.bin_index;
      do @(posedge clk_i); while (!in_if.ready);
      burst--;
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    hist_sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_gate(int lo, int hi, bit single);
    write_reg(CFG_GATE_LOW, CFG_DATA_W'(lo));
    write_reg(CFG_GATE_HIGH, CFG_DATA_W'(hi));
    write_reg(CFG_SINGLE_ALPHA, CFG_DATA_W'(single));
    n_settings++;
  endtask

  // wait out owed reads, then let a trailing gate search and walk finish
  task automatic settle();
    while (hist_sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int p;
    int lo;
    hist_sb = new();
    idle_run = 0;
    n_settings = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_HIT;
    in_if.energy = '0;
    in_if.event_end = 1'b0;
    in_if.alpha_count = '0;
    in_if.bin_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_GATE_LOW;
    cfg_if.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // narrow gate around energy 16'h1000, bin 256: cleared bins, single-hit event,
    // read inside an event, full buffer with high-energy hits, hit on the gate edge
    set_gate(16'h0FF0, 16'h1010, 1'b0);
    push_read('0);
    push_read(BIN_IDX_W'(NUM_BINS - 1));
    push_hit(16'h1000, 1'b1, 4'h0);
    push_hit(16'h0005, 1'b0, 4'h0);
    push_hit(16'h1000, 1'b0, 4'h0);
    push_read('0);
    repeat (MAX_HITS - 2) push_hit(16'hFFFF, 1'b0, 4'hF);
    push_hit(16'h0017, 1'b1, 4'hF);
    push_read('0);
    push_read(BIN_IDX_W'(1));
    push_hit(16'h0FF0, 1'b0, 4'h0);
    push_hit(16'h7FF0, 1'b1, 4'h0);
    push_read(BIN_IDX_W'(NUM_BINS - 1));
    gen_run(150);
    drive_beats();
    settle();

    // alpha mode with a high-energy gate: kept, wrong alpha, gate edges only
    set_gate(16'hF000, 16'hFFFF, 1'b1);
    push_hit(16'hF800, 1'b0, 4'h0);
    push_hit(16'h7FF5, 1'b1, 4'h1);
    push_hit(16'h7FF5, 1'b0, 4'h0);
    push_hit(16'hF800, 1'b1, 4'h2);
    push_hit(16'hFFFF, 1'b0, 4'h1);
    push_hit(16'hF000, 1'b1, 4'h1);
    push_read(BIN_IDX_W'(NUM_BINS - 1));
    gen_run(150);
    drive_beats();
    settle();

    // widest gate, then inverted and one-wide gates where nothing counts
    set_gate(0, 16'hFFFF, 1'b0);
    gen_run(150);
    drive_beats();
    settle();
    set_gate(16'hFFFF, 0, 1'b1);
    gen_run(100);
    drive_beats();
    settle();
    set_gate(16'h1000, 16'h1001, 1'b0);
    gen_run(100);
    drive_beats();
    settle();

    // random gates
    for (p = 0; p < 3; p++) begin
      lo = int'($urandom_range(0, 16'hF000));
      set_gate(lo, lo + int'($urandom_range(2, 16'h1000)), $urandom_range(0, 1) == 1);
      gen_run(120);
      drive_beats();
      settle();
    end

    $display("covered %0d hits in %0d events, %0d of them gated into the histogram",
             hist_sb.hits_taken, hist_sb.events_closed, hist_sb.events_counted);
    $display("%0d bin reads matched over %0d gate settings (open, inverted, one-wide, random)",
             hist_sb.reads_ok, n_settings);
    if (hist_sb.errors == 0 && hist_sb.pending_reads.size() == 0) begin
      $display("tb_coincidence_gated_histogrammer: PASS");
    end else begin
      $display("tb_coincidence_gated_histogrammer: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/cgh_pkg.sv
rtl/cgh_in_if.sv
rtl/cgh_out_if.sv
rtl/cgh_cfg_if.sv
rtl/cgh_ram.sv
rtl/cgh_cfg_regs.sv
rtl/cgh_ctrl.sv
rtl/coincidence_gated_histogrammer.sv
rtl/cgh_checker.sv
dv/tb_coincidence_gated_histogrammer.sv
